>>> rtl/core/euler_angles_to_rotation_matrix_defines.svh
// assertion macros for the euler angle to rotation matrix block
// no dependencies; included by the checker file
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH

// generic clocked assertion with active-low reset disable
`define EAMAT_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// shorthand for the block clock and reset
`define EAMAT_ASSERT_CLK(lbl, prop, msg) \
	`EAMAT_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

>>> rtl/core/eamat_pkg.sv
// shared fixed point types, constants and multiply helper
// no dependencies
package eamat_pkg;

	// internal values: signed Q3.32
	localparam int FRAC = 32;
	localparam int VW   = 36;
	typedef logic signed [VW-1:0] fix_t;

	localparam fix_t ONE     = 36'sh1_0000_0000;
	localparam fix_t PI      = 36'sh3_243F_6A89;
	localparam fix_t HALF_PI = 36'sh1_921F_B544;

	// horner coefficients in u = x*x/4, innermost term first
	localparam fix_t SIN_INIT = 36'sd54;
	localparam fix_t COS_INIT = 36'sd13;
	localparam fix_t SIN_C [7] = '{
		36'sd2825, 36'sd110180, 36'sd3029959, 36'sd54539267,
		36'sd572662306, 36'sd2863311531, ONE
	};
	localparam fix_t COS_C [8] = '{
		36'sd807, 36'sd36727, 36'sd1211984, 36'sd27269634,
		36'sd381774871, 36'sd2863311531, 36'sd8589934592, ONE
	};

	localparam int HSTEPS = 8;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} matrix_t;

	// fixed point product, floor of (a*b) / 2^32
	function automatic fix_t fmul(fix_t a, fix_t b);
		logic signed [2*VW-1:0] p;
		p = a * b;
		return p[VW+FRAC-1:FRAC];
	endfunction

endpackage

>>> rtl/core/eamat_angle_if.sv
// input channel carrying the three euler angles
// no dependencies
interface eamat_angle_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] roll_angle;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] yaw_angle;

	modport source(output valid, output roll_angle, output pitch_angle,
		output yaw_angle, input ready);
	modport sink(input valid, input roll_angle, input pitch_angle,
		input yaw_angle, output ready);
endinterface

>>> rtl/core/eamat_matrix_if.sv
// output channel carrying the nine matrix entries
// no dependencies
interface eamat_matrix_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] m00;
	logic signed [15:0] m01;
	logic signed [15:0] m02;
	logic signed [15:0] m10;
	logic signed [15:0] m11;
	logic signed [15:0] m12;
	logic signed [15:0] m20;
	logic signed [15:0] m21;
	logic signed [15:0] m22;

	modport source(output valid, output m00, output m01, output m02, output m10,
		output m11, output m12, output m20, output m21, output m22, input ready);
	modport sink(input valid, input m00, input m01, input m02, input m10,
		input m11, input m12, input m20, input m21, input m22, output ready);
endinterface

>>> rtl/core/euler_angles_to_rotation_matrix.sv
// Euler angles (Z-Y-X) to rotation matrix, top level.
// Input channel ang carries roll, pitch and yaw in signed Q2.13 radians;
// output channel mat carries the nine entries of Rz*Ry*Rx in signed Q1.14,
// rounded to nearest and clamped to plus or minus one.
// A transaction is taken when valid and ready are both high.
// From input transaction to result valid the pipeline has one stage
// for angle reduction, one for the square, eight horner stages of the
// sine/cosine polynomial, two product levels, one sum and one rounding
// stage whose register drives the output.
// Throughput is one transaction per cycle; the whole pipeline advances
// together when the output register is empty or being taken.
// When the receiver stalls with a result waiting, the pipeline freezes and
// ang.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// Depends on eamat_pkg, eamat_angle_if, eamat_matrix_if, eamat_sincos,
// eamat_matrix.
module euler_angles_to_rotation_matrix (
	input  logic           clk,
	input  logic           arst_n,
	eamat_angle_if.sink    ang,
	eamat_matrix_if.source mat
);
	import eamat_pkg::*;

	localparam int DEPTH = 14;

	logic [DEPTH-1:0] vld_q;
	logic             en;
	fix_t             sph, cph, sth, cth, sps, cps;
	matrix_t          res;

	// pipeline advances unless the output holds an untaken result
	assign en        = !vld_q[DEPTH-1] || mat.ready;
	assign ang.ready = en;

	// valid bits travel alongside the data stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], ang.valid};
		end
	end

	eamat_sincos u_roll (
		.clk(clk), .en(en), .angle(ang.roll_angle), .sine(sph), .cosine(cph)
	);
	eamat_sincos u_pitch (
		.clk(clk), .en(en), .angle(ang.pitch_angle), .sine(sth), .cosine(cth)
	);
	eamat_sincos u_yaw (
		.clk(clk), .en(en), .angle(ang.yaw_angle), .sine(sps), .cosine(cps)
	);

	eamat_matrix u_matrix (
		.clk(clk), .en(en),
		.sph(sph), .cph(cph), .sth(sth), .cth(cth), .sps(sps), .cps(cps),
		.mat(res)
	);

	// output channel
	assign mat.valid = vld_q[DEPTH-1];
	assign mat.m00   = res.m00;
	assign mat.m01   = res.m01;
	assign mat.m02   = res.m02;
	assign mat.m10   = res.m10;
	assign mat.m11   = res.m11;
	assign mat.m12   = res.m12;
	assign mat.m20   = res.m20;
	assign mat.m21   = res.m21;
	assign mat.m22   = res.m22;

endmodule

>>> rtl/core/eamat_sincos.sv
// pipelined sine and cosine of one Q2.13 angle, ten register stages
// depends on eamat_pkg
module eamat_sincos (
	input  logic            clk,
	input  logic            en,
	input  logic signed [15:0] angle,
	output eamat_pkg::fix_t sine,
	output eamat_pkg::fix_t cosine
);
	import eamat_pkg::*;

	fix_t x_s1;
	logic flip_s1;
	fix_t x_s2;
	fix_t u_s2;
	logic flip_s2;

	fix_t xa;
	fix_t y;

	// horner stage registers, one entry per stage
	fix_t sacc_s [HSTEPS];
	fix_t cacc_s [HSTEPS];
	fix_t xd_s   [HSTEPS];
	fix_t ud_s   [HSTEPS];
	logic fd_s   [HSTEPS];

	fix_t s_in [HSTEPS];
	fix_t c_in [HSTEPS];
	fix_t x_in [HSTEPS];
	fix_t u_in [HSTEPS];
	logic f_in [HSTEPS];

	// angle to Q3.32 and reduction by pi into [-pi/2, pi/2]
	assign xa = {angle[15], angle, 19'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			if (xa > HALF_PI) begin
				x_s1    <= xa - PI;
				flip_s1 <= 1'b1;
			end else if (xa < -HALF_PI) begin
				x_s1    <= xa + PI;
				flip_s1 <= 1'b1;
			end else begin
				x_s1    <= xa;
				flip_s1 <= 1'b0;
			end
		end
	end

	// square and scale by a quarter
	assign y = fmul(x_s1, x_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= x_s1;
			u_s2    <= y >>> 2;
			flip_s2 <= flip_s1;
		end
	end

	// stage inputs: first stage starts from the innermost coefficients
	always_comb begin
		s_in[0] = SIN_INIT;
		c_in[0] = COS_INIT;
		x_in[0] = x_s2;
		u_in[0] = u_s2;
		f_in[0] = flip_s2;
		for (int k = 1; k < HSTEPS; k++) begin
			s_in[k] = sacc_s[k-1];
			c_in[k] = cacc_s[k-1];
			x_in[k] = xd_s[k-1];
			u_in[k] = ud_s[k-1];
			f_in[k] = fd_s[k-1];
		end
	end

	// horner steps; last sine step multiplies by x, last step applies the flip
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < HSTEPS; k++) begin
				xd_s[k] <= x_in[k];
				ud_s[k] <= u_in[k];
				fd_s[k] <= f_in[k];
				if (k < HSTEPS-1) begin
					sacc_s[k] <= SIN_C[k] - fmul(u_in[k], s_in[k]);
					cacc_s[k] <= COS_C[k] - fmul(u_in[k], c_in[k]);
				end else if (f_in[k]) begin
					sacc_s[k] <= -fmul(x_in[k], s_in[k]);
					cacc_s[k] <= fmul(u_in[k], c_in[k]) - COS_C[k];
				end else begin
					sacc_s[k] <= fmul(x_in[k], s_in[k]);
					cacc_s[k] <= COS_C[k] - fmul(u_in[k], c_in[k]);
				end
			end
		end
	end

	assign sine   = sacc_s[HSTEPS-1];
	assign cosine = cacc_s[HSTEPS-1];

endmodule

>>> rtl/core/eamat_matrix.sv
// products, sums and Q1.14 rounding of the rotation matrix, four stages
// depends on eamat_pkg
module eamat_matrix (
	input  logic               clk,
	input  logic               en,
	input  eamat_pkg::fix_t    sph,
	input  eamat_pkg::fix_t    cph,
	input  eamat_pkg::fix_t    sth,
	input  eamat_pkg::fix_t    cth,
	input  eamat_pkg::fix_t    sps,
	input  eamat_pkg::fix_t    cps,
	output eamat_pkg::matrix_t mat
);
	import eamat_pkg::*;

	fix_t ss_s1, sc_s1, p00_s1, p10_s1, p21_s1, p22_s1;
	fix_t a01_s1, a11_s1, a02_s1, a12_s1, cps_s1, sps_s1, n20_s1;
	fix_t b01_s2, b02_s2, b11_s2, b12_s2;
	fix_t p00_s2, p10_s2, p21_s2, p22_s2, a01_s2, a11_s2, a02_s2, a12_s2, n20_s2;
	fix_t e_s3 [9];
	matrix_t m_s4;

	// round half away from zero to Q1.14 and clamp to one
	function automatic logic signed [15:0] to_q14(fix_t v);
		logic [VW-1:0] mag;
		logic [17:0]   q;
		mag = v[VW-1] ? VW'(-v) : VW'(v);
		q   = 18'((mag + VW'(36'd131072)) >> 18);
		if (q > 18'd16384)
			q = 18'd16384;
		return v[VW-1] ? -(16'(q)) : 16'(q);
	endfunction

	// first level products
	always_ff @(posedge clk) begin
		if (en) begin
			ss_s1  <= fmul(sth, sph);
			sc_s1  <= fmul(sth, cph);
			p00_s1 <= fmul(cps, cth);
			p10_s1 <= fmul(sps, cth);
			p21_s1 <= fmul(cth, sph);
			p22_s1 <= fmul(cth, cph);
			a01_s1 <= fmul(sps, cph);
			a11_s1 <= fmul(cps, cph);
			a02_s1 <= fmul(sps, sph);
			a12_s1 <= fmul(cps, sph);
			cps_s1 <= cps;
			sps_s1 <= sps;
			n20_s1 <= -sth;
		end
	end

	// second level products
	always_ff @(posedge clk) begin
		if (en) begin
			b01_s2 <= fmul(cps_s1, ss_s1);
			b02_s2 <= fmul(cps_s1, sc_s1);
			b11_s2 <= fmul(sps_s1, ss_s1);
			b12_s2 <= fmul(sps_s1, sc_s1);
			p00_s2 <= p00_s1;
			p10_s2 <= p10_s1;
			p21_s2 <= p21_s1;
			p22_s2 <= p22_s1;
			a01_s2 <= a01_s1;
			a11_s2 <= a11_s1;
			a02_s2 <= a02_s1;
			a12_s2 <= a12_s1;
			n20_s2 <= n20_s1;
		end
	end

	// entry sums
	always_ff @(posedge clk) begin
		if (en) begin
			e_s3[0] <= p00_s2;
			e_s3[1] <= b01_s2 - a01_s2;
			e_s3[2] <= b02_s2 + a02_s2;
			e_s3[3] <= p10_s2;
			e_s3[4] <= b11_s2 + a11_s2;
			e_s3[5] <= b12_s2 - a12_s2;
			e_s3[6] <= n20_s2;
			e_s3[7] <= p21_s2;
			e_s3[8] <= p22_s2;
		end
	end

	// rounding into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			m_s4.m00 <= to_q14(e_s3[0]);
			m_s4.m01 <= to_q14(e_s3[1]);
			m_s4.m02 <= to_q14(e_s3[2]);
			m_s4.m10 <= to_q14(e_s3[3]);
			m_s4.m11 <= to_q14(e_s3[4]);
			m_s4.m12 <= to_q14(e_s3[5]);
			m_s4.m20 <= to_q14(e_s3[6]);
			m_s4.m21 <= to_q14(e_s3[7]);
			m_s4.m22 <= to_q14(e_s3[8]);
		end
	end

	assign mat = m_s4;

endmodule

>>> rtl/core/eamat_checker.sv
// port-level checks for the euler angle to rotation matrix block, and bind
// depends on euler_angles_to_rotation_matrix_defines.svh
`include "euler_angles_to_rotation_matrix_defines.svh"

module eamat_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] m00,
	input logic signed [15:0] m20
);

	// stalled result stays offered
	`EAMAT_ASSERT_CLK(a_out_hold, (out_valid && !out_ready |=> out_valid), "result dropped")

	// stalled result payload holds, checked on m00 and m20
	`EAMAT_ASSERT_CLK(a_out_stable, (out_valid && !out_ready |=> $stable(m00) && $stable(m20)), "result changed")

	// input side frozen exactly when a result is stuck
	`EAMAT_ASSERT_CLK(a_ready, (in_ready == (!out_valid || out_ready)), "ready mismatch")

	// entries m00 and m20 clamped to plus or minus one
	`EAMAT_ASSERT_CLK(a_range, (out_valid |-> (m00 <= 16'sd16384) && (m00 >= -16'sd16384) && (m20 <= 16'sd16384) && (m20 >= -16'sd16384)), "entry out of range")

	// no input accepted while a result is stuck
	`EAMAT_ASSERT_CLK(a_no_accept_when_stuck, (in_valid && out_valid && !out_ready |-> !in_ready), "accepted while stalled")

endmodule

bind euler_angles_to_rotation_matrix eamat_checker u_eamat_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(ang.valid),
	.in_ready(ang.ready),
	.out_valid(mat.valid),
	.out_ready(mat.ready),
	.m00(mat.m00),
	.m20(mat.m20)
);
